### sv/scf_pkg.sv
// ---------------------------------------------------------------------------
// Speed command filter package
// Shared types, register codes and fixed widths for the speed command filter.
// ---------------------------------------------------------------------------
`default_nettype none

package scf_pkg;

   localparam int DATA_W     = 32;
   localparam int CFG_W      = 31;
   localparam int GAIN_W     = 16;
   localparam int LP_SHIFT   = 16;
   localparam int MULW       = 33;
   localparam int PRODW      = 2 * MULW;
   localparam int ACCW       = PRODW + 1;
   localparam int SUMW       = ACCW + 1;
   localparam int DENW       = 33;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;

   localparam logic [GAIN_W:0] GAIN_ONE = 17'h1_0000;

   localparam logic [CSR_IDX_W-1:0] REG_LAT_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PROC_NOISE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEAS_NOISE = 3'd4;

   typedef struct packed {
      logic signed [DATA_W-1:0] linear_speed;
      logic signed [DATA_W-1:0] turn_rate;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_linear_speed;
      logic signed [DATA_W-1:0] out_turn_rate;
      logic                     bypassed;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_PRED,
      S_KDIV,
      S_KWAIT,
      S_EMUL,
      S_VMUL,
      S_EUPD,
      S_VARUPD,
      S_CLAMP,
      S_LWAIT,
      S_LP1,
      S_LP2,
      S_LP3,
      S_LP4,
      S_LP5,
      S_LP6,
      S_LP7,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

### sv/scf_div.sv
// ---------------------------------------------------------------------------
// Speed command filter divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module scf_div #(
   parameter int NUMW = 48,
   parameter int CNTW = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [NUMW-1:0]           num,
   input  wire logic [scf_pkg::DENW-1:0]  den,
   input  wire logic [scf_pkg::DENW-1:0]  rem_init,
   input  wire logic [CNTW-1:0]           first_bit,
   output logic                           done,
   output logic [NUMW-1:0]                quot
);
   import scf_pkg::*;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DENW-1:0] rem_ff, rem_in;
   logic [DENW-1:0] den_ff, den_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic [NUMW-1:0] quot_ff, quot_in;
   logic [DENW:0]   part;
   logic            fits;

   assign part = {rem_ff, num_ff[cnt_ff]};
   assign fits = (part >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = first_bit;
         rem_in  = rem_init;
         den_in  = den;
         num_in  = num;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? DENW'(part - {1'b0, den_ff}) : part[DENW-1:0];
         quot_in = {quot_ff[NUMW-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### sv/scf_mul.sv
// ---------------------------------------------------------------------------
// Speed command filter multiplier
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
`default_nettype none

module scf_mul (
   input  wire logic                              clock,
   input  wire logic signed [scf_pkg::MULW-1:0]   a,
   input  wire logic signed [scf_pkg::MULW-1:0]   b,
   output logic signed [scf_pkg::PRODW-1:0]       prod
);
   import scf_pkg::*;

   logic signed [PRODW-1:0] prod_ff, prod_in;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### sv/speed_command_filter.sv
// ---------------------------------------------------------------------------
// Speed command filter
// Scalar Kalman filter on the linear speed, lateral acceleration limit and
// first-order low-pass smoothing of speed and turn rate.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         req_valid/stall    req_type (speed, turn rate)
//   rsp_     out        rsp_valid/stall    rsp_type (speed, turn rate, bypass)
//   csr_     in         APB-style access   32-bit registers at 4*i
//
// One command is processed at a time by a sequencer over one shared multiplier
// and one bit-serial divider. Every command waits on the Kalman gain division;
// a zero turn rate bypasses the limit and low-pass steps, and the limit
// division runs only when the lateral limit engages.
// Reset is synchronous; it restores control, CSR and filter state only.
// A stalled result is held in the output register while the next command is
// already taken in; it waits before delivery until that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module speed_command_filter #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire scf_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output scf_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [scf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   import scf_pkg::*;

   localparam int NUM_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int K_W   = FRAC_BITS + 1;

   localparam logic [K_W-1:0]   ONE      = K_W'(1) << FRAC_BITS;
   localparam logic [CFG_W-1:0] LIM_RST  = CFG_W'(5 * (2 ** FRAC_BITS));
   localparam logic [CFG_W-1:0] PN_RST   = CFG_W'((2 ** FRAC_BITS + 50) / 100);
   localparam logic [CFG_W-1:0] R_RST    = CFG_W'((3 * (2 ** FRAC_BITS) + 5) / 10);
   localparam logic [31:0]      VAR_RST  = 32'((2 ** FRAC_BITS + 50) / 100);
   localparam logic [31:0]      X_RST    = 32'(2 ** FRAC_BITS);
   localparam logic [NUM_W-1:0] MAX_Q    = NUM_W'(64'h7FFF_FFFF);
   localparam logic [NUM_W-1:0] MIN_Q    = NUM_W'(64'h8000_0000);

   localparam logic signed [ACCW-1:0] HALF_FRAC = ACCW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACCW-1:0] HALF_LP   = ACCW'(1) <<< (LP_SHIFT - 1);
   localparam logic signed [SUMW-1:0] SAT_MAX   = SUMW'(64'sh7FFF_FFFF);
   localparam logic signed [SUMW-1:0] SAT_MIN   = ~SAT_MAX;

   function automatic logic signed [ACCW-1:0] round_shift(
      input logic signed [ACCW-1:0] val,
      input logic                   use_frac
   );
      logic signed [ACCW-1:0] biased_frac;
      logic signed [ACCW-1:0] biased_lp;
      biased_frac = val + HALF_FRAC;
      biased_lp   = val + HALF_LP;
      return use_frac ? (biased_frac >>> FRAC_BITS) : (biased_lp >>> LP_SHIFT);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUMW-1:0] val);
      if (val > SAT_MAX) begin
         return 32'sh7FFF_FFFF;
      end else if (val < SAT_MIN) begin
         return 32'sh8000_0000;
      end else begin
         return val[31:0];
      end
   endfunction

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  lim_ff, lim_in;
   logic [GAIN_W-1:0] gs_ff, gs_in;
   logic [GAIN_W-1:0] gt_ff, gt_in;
   logic [CFG_W-1:0]  pn_ff, pn_in;
   logic [CFG_W-1:0]  r_ff, r_in;

   logic signed [31:0] x_ff, x_in;
   logic [31:0]        var_ff, var_in;
   logic signed [31:0] ss_ff, ss_in;
   logic signed [31:0] st_ff, st_in;

   logic signed [31:0]     z_ff, z_in;
   logic signed [31:0]     w_ff, w_in;
   logic [31:0]            p_ff, p_in;
   logic                   den_zero_ff, den_zero_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic signed [31:0]     v_ff, v_in;
   logic signed [ACCW-1:0] rnd_ff, rnd_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic                   bypass_ff, bypass_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic signed [MULW-1:0]  mul_a, mul_b;
   logic signed [PRODW-1:0] prod;
   logic [PRODW-1:0]        prod_mag;

   logic                    div_start;
   logic [NUM_W-1:0]        div_num;
   logic [DENW-1:0]         div_den;
   logic [DENW-1:0]         div_rem_init;
   logic [CNT_W-1:0]        div_first;
   logic                    div_done;
   logic [NUM_W-1:0]        div_quot;

   logic [32:0]             p_sum;
   logic [31:0]             p_pred;
   logic [DENW-1:0]         k_den;
   logic [NUM_W-1:0]        lim_num;
   logic signed [DENW-1:0]  w_ext;
   logic [DENW-1:0]         w_mag;
   logic                    over_limit;
   logic [31:0]             neg_q;
   logic signed [31:0]      lim_v;

   logic                    csr_wr;
   logic [CSR_IDX_W-1:0]    csr_idx;

   scf_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   scf_div #(
      .NUMW (NUM_W),
      .CNTW (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .num       (div_num),
      .den       (div_den),
      .rem_init  (div_rem_init),
      .first_bit (div_first),
      .done      (div_done),
      .quot      (div_quot)
   );

   assign p_sum    = {1'b0, var_ff} + {2'b00, pn_ff};
   assign p_pred   = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
   assign k_den    = {1'b0, p_ff} + {2'b00, r_ff};
   assign lim_num  = {1'b0, lim_ff, {FRAC_BITS{1'b0}}};
   assign w_ext    = DENW'(w_ff);
   assign w_mag    = w_ext[DENW-1] ? DENW'(-w_ext) : DENW'(w_ext);
   assign prod_mag = prod[PRODW-1] ? PRODW'(-prod) : PRODW'(prod);
   assign over_limit = (prod_mag > PRODW'(lim_num));
   assign neg_q    = 32'd0 - div_quot[31:0];

   always_comb begin
      if (!w_ff[31]) begin
         lim_v = (div_quot > MAX_Q) ? 32'sh7FFF_FFFF : div_quot[31:0];
      end else begin
         lim_v = (div_quot > MIN_Q) ? 32'sh8000_0000 : neg_q;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PRED;
         end
         S_PRED:   state_in = S_KDIV;
         S_KDIV:   state_in = S_KWAIT;
         S_KWAIT: begin
            if (div_done) state_in = S_EMUL;
         end
         S_EMUL:   state_in = S_VMUL;
         S_VMUL:   state_in = S_EUPD;
         S_EUPD:   state_in = S_VARUPD;
         S_VARUPD: state_in = (w_ff == '0) ? S_OUT : S_CLAMP;
         S_CLAMP:  state_in = over_limit ? S_LWAIT : S_LP1;
         S_LWAIT: begin
            if (div_done) state_in = S_LP1;
         end
         S_LP1:    state_in = S_LP2;
         S_LP2:    state_in = S_LP3;
         S_LP3:    state_in = S_LP4;
         S_LP4:    state_in = S_LP5;
         S_LP5:    state_in = S_LP6;
         S_LP6:    state_in = S_LP7;
         S_LP7:    state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      z_in         = z_ff;
      w_in         = w_ff;
      p_in         = p_ff;
      den_zero_in  = den_zero_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      var_in       = var_ff;
      v_in         = v_ff;
      ss_in        = ss_ff;
      st_in        = st_ff;
      rnd_in       = rnd_ff;
      acc_in       = acc_ff;
      bypass_in    = bypass_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      div_rem_init = '0;
      div_first    = '0;
      case (state_ff)
         S_IDLE: begin
            z_in = req_data.linear_speed;
            w_in = req_data.turn_rate;
         end
         S_PRED: begin
            p_in = p_pred;
         end
         S_KDIV: begin
            div_start    = 1'b1;
            div_num      = {p_ff, {FRAC_BITS{1'b0}}};
            div_den      = k_den;
            div_rem_init = {2'b00, p_ff[31:1]};
            div_first    = CNT_W'(FRAC_BITS);
            den_zero_in  = (k_den == '0);
         end
         S_KWAIT: begin
            if (div_done) k_in = den_zero_ff ? '0 : div_quot[K_W-1:0];
         end
         S_EMUL: begin
            mul_a = MULW'(z_ff) - MULW'(x_ff);
            mul_b = MULW'(k_ff);
         end
         S_VMUL: begin
            mul_a  = MULW'(p_ff);
            mul_b  = MULW'(ONE - k_ff);
            rnd_in = round_shift(ACCW'(prod), 1'b1);
         end
         S_EUPD: begin
            x_in   = sat32(SUMW'(x_ff) + SUMW'(rnd_ff));
            rnd_in = round_shift(ACCW'(prod), 1'b1);
         end
         S_VARUPD: begin
            var_in    = rnd_ff[31:0];
            mul_a     = MULW'(x_ff);
            mul_b     = MULW'(w_ff);
            bypass_in = (w_ff == '0);
         end
         S_CLAMP: begin
            if (over_limit) begin
               div_start    = 1'b1;
               div_num      = lim_num;
               div_den      = w_mag;
               div_rem_init = '0;
               div_first    = CNT_W'(NUM_W - 1);
            end else begin
               v_in = x_ff;
            end
         end
         S_LWAIT: begin
            if (div_done) v_in = lim_v;
         end
         S_LP1: begin
            mul_a = MULW'(ss_ff);
            mul_b = MULW'(gs_ff);
         end
         S_LP2: begin
            acc_in = ACCW'(prod);
            mul_a  = MULW'(v_ff);
            mul_b  = MULW'(GAIN_ONE - {1'b0, gs_ff});
         end
         S_LP3: begin
            acc_in = acc_ff + ACCW'(prod);
            mul_a  = MULW'(st_ff);
            mul_b  = MULW'(gt_ff);
         end
         S_LP4: begin
            rnd_in = round_shift(acc_ff, 1'b0);
            acc_in = ACCW'(prod);
            mul_a  = MULW'(w_ff);
            mul_b  = MULW'(GAIN_ONE - {1'b0, gt_ff});
         end
         S_LP5: begin
            ss_in  = sat32(SUMW'(rnd_ff));
            acc_in = acc_ff + ACCW'(prod);
         end
         S_LP6: begin
            rnd_in = round_shift(acc_ff, 1'b0);
         end
         S_LP7: begin
            st_in = sat32(SUMW'(rnd_ff));
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (bypass_ff) begin
                  rsp_data_in.out_linear_speed = z_ff;
                  rsp_data_in.out_turn_rate    = w_ff;
                  rsp_data_in.bypassed         = 1'b1;
               end else begin
                  rsp_data_in.out_linear_speed = ss_ff;
                  rsp_data_in.out_turn_rate    = st_ff;
                  rsp_data_in.bypassed         = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      lim_in = lim_ff;
      gs_in  = gs_ff;
      gt_in  = gt_ff;
      pn_in  = pn_ff;
      r_in   = r_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_LAT_LIMIT:  lim_in = csr_pwdata[CFG_W-1:0];
            REG_SPEED_GAIN: gs_in  = csr_pwdata[GAIN_W-1:0];
            REG_TURN_GAIN:  gt_in  = csr_pwdata[GAIN_W-1:0];
            REG_PROC_NOISE: pn_in  = csr_pwdata[CFG_W-1:0];
            REG_MEAS_NOISE: r_in   = csr_pwdata[CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_LAT_LIMIT:  csr_prdata = 32'(lim_ff);
         REG_SPEED_GAIN: csr_prdata = 32'(gs_ff);
         REG_TURN_GAIN:  csr_prdata = 32'(gt_ff);
         REG_PROC_NOISE: csr_prdata = 32'(pn_ff);
         REG_MEAS_NOISE: csr_prdata = 32'(r_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lim_ff       <= LIM_RST;
         gs_ff        <= '0;
         gt_ff        <= '0;
         pn_ff        <= PN_RST;
         r_ff         <= R_RST;
         x_ff         <= X_RST;
         var_ff       <= VAR_RST;
         ss_ff        <= '0;
         st_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lim_ff       <= lim_in;
         gs_ff        <= gs_in;
         gt_ff        <= gt_in;
         pn_ff        <= pn_in;
         r_ff         <= r_in;
         x_ff         <= x_in;
         var_ff       <= var_in;
         ss_ff        <= ss_in;
         st_ff        <= st_in;
      end
      z_ff        <= z_in;
      w_ff        <= w_in;
      p_ff        <= p_in;
      den_zero_ff <= den_zero_in;
      k_ff        <= k_in;
      v_ff        <= v_in;
      rnd_ff      <= rnd_in;
      acc_ff      <= acc_in;
      bypass_ff   <= bypass_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input taken again while a command is in progress.");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("Result presented outside the delivery step.");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_KWAIT || state_ff == S_LWAIT))
      else $error("Divider finished while the sequencer was not waiting.");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMUL) |-> (k_ff <= ONE))
      else $error("Kalman gain above one.");

endmodule

`default_nettype wire
